// File: hw/rtl/fdli_pkg.sv
// fdli_pkg: shared types and constants for the feedback delay line with interpolation
// holds default sizes, register indexes, gain limits and the sequencer state type
// no dependencies
`timescale 1ns / 1ps

package fdli_pkg;

  // default sizes
  localparam int unsigned BufferDepthDef = 4096;
  localparam int unsigned SampleBitsDef  = 16;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] RegDelay    = 2'd0;
  localparam logic [1:0] RegFeedback = 2'd1;
  localparam logic [1:0] RegMix      = 2'd2;

  // gain limits
  localparam int FbLimit = 32735;
  localparam int MixOne  = 32768;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_WRITE
  } fdli_state_e;

endpackage

// File: hw/rtl/feedback_delay_line_interp_unit.sv
// feedback_delay_line_interp_unit: fractional delay line, linear interpolation, feedback
// uses fdli_pkg for sizes, register indexes and the state type
`timescale 1ns / 1ps

// Usage:
//   Input channel in_valid_i/in_ready_o carries one signed sample per request.
//   Output channel out_valid_o/out_ready_i returns one mixed sample per request.
//   Registers (APB, byte address 4*i): 0 delay (Q12.8), 1 feedback gain (Q1.15),
//   2 wet mix (Q1.15, unsigned, at most 1.0). Values out of range are clamped when written.
//   The result is registered as the sequencer leaves its WRITE state, after READ and MUL.
//   A new sample is accepted only in idle, after the sequence read / interpolate,
//   multiply, write back with mix, and return to idle; both taps come from the
//   two read ports of the delay memory in the same cycle.
//   The result sits in an output register, so the next sample is accepted while
//   it waits. If the receiver stalls longer, the following sample holds in its
//   write-back step, with the memory write held back, until the output frees.
//   Reset clears the registers and the write pointer. The delay memory is not
//   swept: a fill mark (write pointer plus a wrapped flag) makes entries not yet
//   written since reset read as zero, so the block is ready at once after reset.
module feedback_delay_line_interp_unit #(
  parameter int unsigned BUFFER_DEPTH = fdli_pkg::BufferDepthDef,
  parameter int unsigned SAMPLE_BITS  = fdli_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  // sample output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_sample_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int S  = SAMPLE_BITS;
  localparam int AW = $clog2(BUFFER_DEPTH);
  // width for pointer arithmetic, holds the depth and the 12-bit integer delay
  localparam int CW = ((AW > 12) ? AW : 12) + 1;
  localparam logic [CW-1:0] DepthC    = CW'(BUFFER_DEPTH);
  localparam logic [AW-1:0] LastIdx   = AW'(BUFFER_DEPTH - 1);
  localparam logic [31:0]   DelayLim  = 32'((BUFFER_DEPTH - 2) * 256);
  localparam logic signed [S+10:0] IntHalf = (S+11)'(128);
  localparam logic signed [S+15:0] FbHalf  = (S+16)'(16384);
  localparam logic signed [S+17:0] MixHalf = (S+18)'(16384);

  // saturate to the sample range
  function automatic logic signed [S-1:0] sat_w(input logic signed [S+2:0] v);
    logic signed [S-1:0] r;
    if (v[S+2:S-1] == {4{1'b0}} || v[S+2:S-1] == {4{1'b1}}) begin
      r = v[S-1:0];
    end else if (v[S+2]) begin
      r = {1'b1, {(S-1){1'b0}}};
    end else begin
      r = {1'b0, {(S-1){1'b1}}};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [19:0]        delay_q;
  logic signed [15:0] gain_q;
  logic [15:0]        mix_q;
  logic               cfg_we;
  logic [19:0]        delay_d;
  logic signed [15:0] gain_d;
  logic [15:0]        mix_d;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  // clamp values on their way in
  always_comb begin
    delay_d = pwdata[19:0];
    if ({12'd0, pwdata[19:0]} > DelayLim) begin
      delay_d = DelayLim[19:0];
    end
    gain_d = $signed(pwdata[15:0]);
    if (gain_d > 16'sd32735) begin
      gain_d = 16'(fdli_pkg::FbLimit);
    end else if (gain_d < -16'sd32735) begin
      gain_d = -16'(fdli_pkg::FbLimit);
    end
    mix_d = pwdata[15:0];
    if (mix_d > 16'(fdli_pkg::MixOne)) begin
      mix_d = 16'(fdli_pkg::MixOne);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      gain_q  <= '0;
      mix_q   <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        fdli_pkg::RegDelay:    delay_q <= delay_d;
        fdli_pkg::RegFeedback: gain_q  <= gain_d;
        fdli_pkg::RegMix:      mix_q   <= mix_d;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      fdli_pkg::RegDelay:    prdata = {12'd0, delay_q};
      fdli_pkg::RegFeedback: prdata = {{16{gain_q[15]}}, gain_q};
      fdli_pkg::RegMix:      prdata = {16'd0, mix_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  fdli_pkg::fdli_state_e state_q, state_d;
  logic in_acc;
  logic mem_we;
  logic out_valid_q, out_valid_d;

  assign in_acc = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdli_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      fdli_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = fdli_pkg::ST_READ;
        end
      end
      fdli_pkg::ST_READ: state_d = fdli_pkg::ST_MUL;
      fdli_pkg::ST_MUL:  state_d = fdli_pkg::ST_WRITE;
      fdli_pkg::ST_WRITE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          mem_we      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = fdli_pkg::ST_IDLE;
        end
      end
      default: state_d = fdli_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // write pointer and fill mark
  // ---------------------------------------------------------------------------
  logic [AW-1:0] wp_q;
  logic          wrapped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (mem_we) begin
      if (wp_q == LastIdx) begin
        wp_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wp_q <= wp_q + AW'(1);
      end
    end
  end

  // tap addresses: newer tap dint samples back, older tap one further
  logic [11:0]   dint;
  logic [CW-1:0] wp_ext, d_ext;
  logic [CW-1:0] new_ext;
  logic [AW-1:0] idx_new, idx_old;

  assign dint   = delay_q[19:8];
  assign wp_ext = CW'(wp_q);
  assign d_ext  = CW'(dint);

  always_comb begin
    if (wp_ext >= d_ext) begin
      new_ext = wp_ext - d_ext;
    end else begin
      new_ext = wp_ext + DepthC - d_ext;
    end
    idx_new = new_ext[AW-1:0];
    idx_old = (idx_new == '0) ? LastIdx : idx_new - AW'(1);
  end

  // ---------------------------------------------------------------------------
  // delay memory: two read ports, one write port
  // ---------------------------------------------------------------------------
  logic signed [S-1:0] mem [BUFFER_DEPTH];
  logic signed [S-1:0] rd_a_q, rd_b_q;
  logic signed [S-1:0] store_d;
  logic                a_ok_q, b_ok_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= store_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_a_q <= mem[idx_new];
      rd_b_q <= mem[idx_old];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ok_q <= 1'b0;
      b_ok_q <= 1'b0;
    end else if (in_acc) begin
      a_ok_q <= wrapped_q | (idx_new < wp_q);
      b_ok_q <= wrapped_q | (idx_old < wp_q);
    end
  end

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  logic signed [S-1:0]  x_q, wet_q, wet_d;
  logic [7:0]           frac_q;
  logic                 bypass_q;
  logic signed [S+15:0] fb_prod_q;
  logic signed [S+16:0] mix_a_q, mix_b_q;
  logic signed [S-1:0]  out_q;

  // linear interpolation between the two taps
  logic signed [S-1:0]  tap_a, tap_b;
  logic signed [S:0]    diff;
  logic signed [S+9:0]  frac_prod;
  logic signed [S+10:0] interp_sum;

  always_comb begin
    tap_a      = a_ok_q ? rd_a_q : '0;
    tap_b      = b_ok_q ? rd_b_q : '0;
    diff       = (S+1)'(tap_b) - (S+1)'(tap_a);
    frac_prod  = diff * $signed({1'b0, frac_q});
    interp_sum = $signed({{3{tap_a[S-1]}}, tap_a, 8'd0}) + (S+11)'(frac_prod) + IntHalf;
    wet_d      = bypass_q ? x_q : sat_w(interp_sum[S+10:8]);
  end

  // feedback sum into the store and dry/wet mix
  logic signed [S+15:0] fb_round;
  logic signed [S+1:0]  store_sum;
  logic signed [S+17:0] mix_sum;

  always_comb begin
    fb_round  = fb_prod_q + FbHalf;
    store_sum = (S+2)'(x_q) + (S+2)'($signed(fb_round[S+15:15]));
    store_d   = sat_w((S+3)'(store_sum));
    mix_sum   = (S+18)'(mix_a_q) + (S+18)'(mix_b_q) + MixHalf;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q      <= in_sample_i;
      frac_q   <= delay_q[7:0];
      bypass_q <= (dint == 12'd0);
    end
    if (state_q == fdli_pkg::ST_READ) begin
      wet_q <= wet_d;
    end
    if (state_q == fdli_pkg::ST_MUL) begin
      fb_prod_q <= wet_q * gain_q;
      mix_a_q   <= x_q * $signed(17'(fdli_pkg::MixOne) - {1'b0, mix_q});
      mix_b_q   <= wet_q * $signed({1'b0, mix_q});
    end
    if (mem_we) begin
      out_q <= sat_w(mix_sum[S+17:15]);
    end
  end

  assign out_sample_o = out_q;

endmodule
